[sv/deq_pkg.sv]
// Shared types, codes and widths of the due-time ordered event queue.
`timescale 1ns / 1ps
package deq_pkg;

  localparam int TIME_W          = 32;
  localparam int TAG_W           = 16;
  localparam int STAT_W          = 2;
  localparam int OCC_W           = 5;
  localparam int ENTRY_W         = TIME_W + TAG_W;
  localparam int QUEUE_DEPTH_DEF = 16;

  // Command codes on the input word
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Status codes on the result word
  typedef enum logic [STAT_W-1:0] {
    STAT_INSERTED = 2'd0,
    STAT_DROPPED  = 2'd1,
    STAT_FIRED    = 2'd2,
    STAT_NONE_DUE = 2'd3
  } deq_status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_TCK_RD,
    S_TCK_CMP,
    S_RESP
  } deq_state_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic in_fire;
    logic is_tick;
    logic full;
    logic empty;
    logic cmp_gt;
    logic k_last;
    logic out_free;
  } deq_stat_t;

  // Control strobes from the sequencer to the datapath
  typedef struct packed {
    logic        in_ready;
    logic        load_item;
    logic        rd_en;
    logic        rd_head;
    logic        wr_en;
    logic        wr_new;
    logic        wr_base;
    logic        k_dec;
    logic        count_inc;
    logic        count_dec;
    logic        head_adv;
    logic        res_load;
    logic        res_take_head;
    deq_status_t res_code;
    logic        out_load;
  } deq_ctrl_t;

endpackage

[sv/deq_if.sv]
// Valid/ready channel interfaces for the input and result words.
`timescale 1ns / 1ps
interface deq_in_if
  import deq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              command;
  logic [TIME_W-1:0] due_time;
  logic [TAG_W-1:0]  entry_tag;
  logic [TIME_W-1:0] now_time;

  modport source (output valid, command, due_time, entry_tag, now_time, input ready);
  modport sink   (input valid, command, due_time, entry_tag, now_time, output ready);
endinterface

interface deq_out_if
  import deq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [TAG_W-1:0]  fired_tag;
  logic [TIME_W-1:0] fired_time;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, status, fired_tag, fired_time, occupancy, input ready);
  modport sink   (input valid, status, fired_tag, fired_time, occupancy, output ready);
endinterface

[sv/due_time_ordered_event_queue_core.sv]
// Top level of the due-time ordered event queue: datapath, RAM and sequencer.
//
//  channel | dir | handshake        | word
//  in_if   | in  | valid / ready    | command, due_time, entry_tag, now_time
//  out_if  | out | valid / ready    | status, fired_tag, fired_time, occupancy
//
// From acceptance until the word sits in the output register: a tick reads
// the head entry and compares it, or goes straight to the result on an empty
// queue; an insert does so when the queue is full or empty, else walks the
// held entries from the tail, moving each later one up a slot until one is
// not later, using the single RAM read port and the one shared time comparator.
// Synchronous reset empties the queue at once; the RAM needs no clearing. A
// new word is taken only while the sequencer is idle; a finished result waits
// in the output register, and the block stalls only if that is full.
`timescale 1ns / 1ps
module due_time_ordered_event_queue_core
  import deq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  deq_in_if.sink   in_if,
  deq_out_if.source out_if
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  deq_stat_t stat;
  deq_ctrl_t ctrl;

  logic [CW-1:0]     count_r;
  logic [AW-1:0]     head_r;
  logic [CW-1:0]     k_r;
  logic [TIME_W-1:0] key_r;
  logic [TAG_W-1:0]  tag_r;
  logic              is_tick;

  deq_status_t       res_status_r;
  logic [TAG_W-1:0]  res_tag_r;
  logic [TIME_W-1:0] res_time_r;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [TAG_W-1:0]  out_tag_r;
  logic [TIME_W-1:0] out_time_r;
  logic [OCC_W-1:0]  out_occ_r;

  logic [CW-1:0]      rd_k, wr_k;
  logic [AW:0]        rd_sum, wr_sum;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [ENTRY_W-1:0] rd_data, wr_data;
  logic               cmp_gt;

  assign is_tick = (in_if.command == CMD_TICK);

  // Shared compare unit: held time against the latched key
  assign cmp_gt = rd_data[TAG_W +: TIME_W] > key_r;

  // Status to the sequencer
  always_comb begin
    stat.in_fire  = in_if.valid && ctrl.in_ready;
    stat.is_tick  = is_tick;
    stat.full     = (count_r == CW'(QUEUE_DEPTH));
    stat.empty    = (count_r == '0);
    stat.cmp_gt   = cmp_gt;
    stat.k_last   = (k_r == CW'(1));
    stat.out_free = !out_valid_r || out_if.ready;
  end

  deq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // Map logical queue positions onto the circular RAM
  always_comb begin
    rd_k   = ctrl.rd_head ? '0 : k_r - CW'(1);
    wr_k   = ctrl.wr_base ? '0 : k_r;
    rd_sum = {1'b0, head_r} + (AW+1)'(rd_k);
    wr_sum = {1'b0, head_r} + (AW+1)'(wr_k);
    rd_addr = (rd_sum >= (AW+1)'(QUEUE_DEPTH)) ? AW'(rd_sum - (AW+1)'(QUEUE_DEPTH))
                                                : AW'(rd_sum);
    wr_addr = (wr_sum >= (AW+1)'(QUEUE_DEPTH)) ? AW'(wr_sum - (AW+1)'(QUEUE_DEPTH))
                                                : AW'(wr_sum);
    // first entry into an empty queue comes straight from the input word
    wr_data = ctrl.wr_base ? {in_if.due_time, in_if.entry_tag}
            : ctrl.wr_new  ? {key_r, tag_r} : rd_data;
  end

  deq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ctrl.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (ctrl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Latch the accepted word; the key is the due time or the current time
  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      key_r <= is_tick ? in_if.now_time : in_if.due_time;
      tag_r <= in_if.entry_tag;
    end
  end

  // Advance count, head and walk position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      head_r  <= '0;
      k_r     <= '0;
    end else begin
      if (ctrl.count_inc) begin
        count_r <= count_r + CW'(1);
      end else if (ctrl.count_dec) begin
        count_r <= count_r - CW'(1);
      end
      if (ctrl.head_adv) begin
        head_r <= (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + AW'(1);
      end
      if (ctrl.load_item) begin
        k_r <= count_r;
      end else if (ctrl.k_dec) begin
        k_r <= k_r - CW'(1);
      end
    end
  end

  // Hold the finished result
  always_ff @(posedge clk) begin
    if (ctrl.res_load) begin
      res_status_r <= ctrl.res_code;
      res_tag_r    <= ctrl.res_take_head ? rd_data[TAG_W-1:0] : '0;
      res_time_r   <= ctrl.res_take_head ? rd_data[TAG_W +: TIME_W] : '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_status_r <= res_status_r;
      out_tag_r    <= res_tag_r;
      out_time_r   <= res_time_r;
      out_occ_r    <= OCC_W'(count_r);
    end
  end

  assign in_if.ready       = ctrl.in_ready;
  assign out_if.valid      = out_valid_r;
  assign out_if.status     = out_status_r;
  assign out_if.fired_tag  = out_tag_r;
  assign out_if.fired_time = out_time_r;
  assign out_if.occupancy  = out_occ_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");
  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.rd_en && !ctrl.rd_head) |-> (k_r != '0 && k_r <= count_r))
    else $error("insert walk outside held entries");
  a_fire_drops_one: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.count_dec |=> count_r == $past(count_r) - CW'(1))
    else $error("fired entry not removed from count");
`endif

endmodule

[sv/deq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module deq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/deq_ctrl.sv]
// Sequencer that drives the shared compare unit and the entry RAM.
`timescale 1ns / 1ps
module deq_ctrl
  import deq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  deq_stat_t stat,
  output deq_ctrl_t ctrl
);

  deq_state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (stat.in_fire) begin
          if (stat.is_tick) begin
            state_nxt = stat.empty ? S_RESP : S_TCK_RD;
          end else if (stat.full || stat.empty) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_INS_RD;
          end
        end
      end
      S_INS_RD:  state_nxt = S_INS_CMP;
      S_INS_CMP: begin
        if (!stat.cmp_gt) begin
          state_nxt = S_RESP;
        end else if (stat.k_last) begin
          state_nxt = S_INS_PUT;
        end else begin
          state_nxt = S_INS_RD;
        end
      end
      S_INS_PUT: state_nxt = S_RESP;
      S_TCK_RD:  state_nxt = S_TCK_CMP;
      S_TCK_CMP: state_nxt = S_RESP;
      S_RESP: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Control strobes
  always_comb begin
    ctrl = '0;
    ctrl.res_code = STAT_NONE_DUE;
    case (state_r)
      S_IDLE: begin
        ctrl.in_ready  = 1'b1;
        ctrl.load_item = stat.in_fire;
        if (stat.in_fire) begin
          if (stat.is_tick) begin
            // empty queue: nothing due
            ctrl.res_load = stat.empty;
            ctrl.res_code = STAT_NONE_DUE;
          end else if (stat.full) begin
            ctrl.res_load = 1'b1;
            ctrl.res_code = STAT_DROPPED;
          end else if (stat.empty) begin
            // first entry goes straight to the head slot
            ctrl.wr_en     = 1'b1;
            ctrl.wr_new    = 1'b1;
            ctrl.wr_base   = 1'b1;
            ctrl.count_inc = 1'b1;
            ctrl.res_load  = 1'b1;
            ctrl.res_code  = STAT_INSERTED;
          end
        end
      end
      S_INS_RD: begin
        ctrl.rd_en = 1'b1;
      end
      S_INS_CMP: begin
        ctrl.wr_en = 1'b1;
        if (stat.cmp_gt) begin
          // later entry moves up one slot
          ctrl.k_dec = 1'b1;
        end else begin
          ctrl.wr_new    = 1'b1;
          ctrl.count_inc = 1'b1;
          ctrl.res_load  = 1'b1;
          ctrl.res_code  = STAT_INSERTED;
        end
      end
      S_INS_PUT: begin
        ctrl.wr_en     = 1'b1;
        ctrl.wr_new    = 1'b1;
        ctrl.count_inc = 1'b1;
        ctrl.res_load  = 1'b1;
        ctrl.res_code  = STAT_INSERTED;
      end
      S_TCK_RD: begin
        ctrl.rd_en   = 1'b1;
        ctrl.rd_head = 1'b1;
      end
      S_TCK_CMP: begin
        ctrl.res_load = 1'b1;
        if (!stat.cmp_gt) begin
          ctrl.res_take_head = 1'b1;
          ctrl.count_dec     = 1'b1;
          ctrl.head_adv      = 1'b1;
          ctrl.res_code      = STAT_FIRED;
        end
      end
      S_RESP: begin
        ctrl.out_load = stat.out_free;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

`ifndef SYNTH
  a_wr_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.wr_en |-> (state_r == S_IDLE || state_r == S_INS_CMP || state_r == S_INS_PUT))
    else $error("entry write outside an insert");
  a_tick_read_then_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TCK_RD |=> state_r == S_TCK_CMP)
    else $error("head read not followed by its compare");
  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |-> (stat.out_free && state_r == S_RESP))
    else $error("result word loaded over a waiting word");
`endif

endmodule
